[hdl/bsm_pkg.sv]
// shared types, codes and constants for the bank switch mapper
package bsm_pkg;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_INIT  = 2'd2;

	// result action codes
	localparam logic [1:0] ACT_PRG    = 2'd0;
	localparam logic [1:0] ACT_CHR    = 2'd1;
	localparam logic [1:0] ACT_MIRROR = 2'd2;
	localparam logic [1:0] ACT_IRQ    = 2'd3;

	// program slots
	localparam logic [2:0] SLOT_PRG_8000 = 3'd0;
	localparam logic [2:0] SLOT_PRG_A000 = 3'd1;
	localparam logic [2:0] SLOT_PRG_C000 = 3'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ALT_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'd1;

	// reset values
	localparam logic [8:0] PRG_COUNT_RST = 9'd16;
	localparam logic [7:0] HIGH_PRG_RST  = 8'(PRG_COUNT_RST - 9'd2);

	// picture bank file
	localparam int CHR_SLOTS = 8;
	localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// one result word
	typedef struct packed {
		logic [1:0] action;
		logic [2:0] slot;
		logic [7:0] bank;
		logic [3:0] mirror_map;
		logic       last;
	} result_t;

	// nametable page map for a mirroring mode
	function automatic logic [3:0] mirror_map_of(input logic [1:0] mode);
		logic [3:0] map;
		case (mode)
			2'd0:    map = 4'd10;
			2'd1:    map = 4'd12;
			2'd2:    map = 4'd0;
			default: map = 4'd15;
		endcase
		return map;
	endfunction

endpackage

[hdl/bank_switch_mapper_irq_unit.sv]
// bank switch mapper with scanline irq: top level
// a word is registered on acceptance and its results enter the result queue when it
// leaves the input word register, which holds it while the queue lacks room for two
// throughput: one word per cycle while the result side keeps up; a swap word gives
// two results, drained one per cycle from the four-entry result queue
// reset: arst_n clears all mapper state at once, no clearing pass; prg_bank_count 16
module bank_switch_mapper_irq_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data,
	// request side
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	// result side
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [2:0]  slot,
	output logic [7:0]  bank,
	output logic [3:0]  mirror_map,
	output logic        last
);

	logic        irq_alt_mode_q;
	logic [8:0]  prg_bank_count_q;
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        room2;
	logic        go;
	logic [1:0]  n_res;
	bsm_pkg::result_t res0;
	bsm_pkg::result_t res1;
	bsm_pkg::result_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_alt_mode_q   <= 1'b0;
			prg_bank_count_q <= bsm_pkg::PRG_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsm_pkg::CFG_IRQ_ALT_MODE:   irq_alt_mode_q   <= cfg_data[0];
				bsm_pkg::CFG_PRG_BANK_COUNT: prg_bank_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// input word register
	assign go       = valid_s1 && room2;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			addr_s1 <= addr;
			data_s1 <= data;
		end
	end

	// mapper state and decode
	bsm_exec u_exec (
		.clk            (clk),
		.arst_n         (arst_n),
		.irq_alt_mode   (irq_alt_mode_q),
		.prg_bank_count (prg_bank_count_q),
		.go             (go),
		.req_type       (req_s1),
		.addr           (addr_s1),
		.data           (data_s1),
		.res0           (res0),
		.res1           (res1),
		.n_res          (n_res)
	);

	// result queue
	bsm_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_push    (go ? n_res : 2'd0),
		.din0      (res0),
		.din1      (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (head)
	);

	assign action     = head.action;
	assign slot       = head.slot;
	assign bank       = head.bank;
	assign mirror_map = head.mirror_map;
	assign last       = head.last;

endmodule

[hdl/bsm_exec.sv]
// mapper state registers and per-word result generation
module bsm_exec (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 irq_alt_mode,
	input  logic [8:0]           prg_bank_count,
	input  logic                 go,
	input  logic [1:0]           req_type,
	input  logic [15:0]          addr,
	input  logic [7:0]           data,
	output bsm_pkg::result_t     res0,
	output bsm_pkg::result_t     res1,
	output logic [1:0]           n_res
);

	logic [7:0] chr_q [bsm_pkg::CHR_SLOTS];
	logic [7:0] low_prg_q;
	logic [7:0] high_prg_q;
	logic [7:0] swap_q;
	logic [1:0] irq_en_q;
	logic [7:0] irq_count_q;
	logic [7:0] irq_reload_q;

	logic [7:0] low_prg_d;
	logic [7:0] high_prg_d;
	logic [7:0] swap_d;
	logic [1:0] irq_en_d;
	logic [7:0] irq_count_d;
	logic [7:0] irq_reload_d;
	logic       chr_we;
	logic       chr_clear;
	logic [bsm_pkg::CHR_IDX_W-1:0] chr_idx;
	logic [7:0] chr_new;

	logic [3:0] page;
	logic [3:0] low4;
	logic [1:0] grp;
	logic       chr_ok;
	logic       chr_odd;
	logic       chr_high;
	logic [7:0] fire_at;

	assign page     = addr[15:12];
	assign low4     = addr[3:0];
	assign grp      = 2'(page[1:0] - 2'd3);
	assign fire_at  = irq_alt_mode ? 8'h00 : 8'hFF;

	// nibble lane decode of a picture bank write
	always_comb begin
		chr_ok   = 1'b1;
		chr_odd  = 1'b0;
		chr_high = 1'b0;
		case (low4)
			4'h0: begin
				chr_odd  = 1'b0;
				chr_high = 1'b0;
			end
			4'h1, 4'h4: begin
				chr_odd  = 1'b1;
				chr_high = 1'b0;
			end
			4'h2, 4'h8: begin
				chr_odd  = 1'b0;
				chr_high = 1'b1;
			end
			4'h3, 4'hC: begin
				chr_odd  = 1'b1;
				chr_high = 1'b1;
			end
			default: chr_ok = 1'b0;
		endcase
	end

	assign chr_idx = {grp, chr_odd};
	assign chr_new = chr_high ? {data[3:0], chr_q[chr_idx][3:0]}
	                          : {chr_q[chr_idx][7:4], data[3:0]};

	// next state and results
	always_comb begin
		low_prg_d    = low_prg_q;
		high_prg_d   = high_prg_q;
		swap_d       = swap_q;
		irq_en_d     = irq_en_q;
		irq_count_d  = irq_count_q;
		irq_reload_d = irq_reload_q;
		chr_we       = 1'b0;
		chr_clear    = 1'b0;
		res0         = '0;
		res1         = '0;
		n_res        = 2'd0;
		case (req_type)
			bsm_pkg::REQ_WRITE: begin
				if (page == 4'h8) begin
					res0.action = bsm_pkg::ACT_PRG;
					res0.bank   = data;
					n_res       = 2'd1;
					if (swap_q[1]) begin
						high_prg_d = data;
						res0.slot  = bsm_pkg::SLOT_PRG_C000;
					end else begin
						low_prg_d = data;
						res0.slot = bsm_pkg::SLOT_PRG_8000;
					end
				end else if (page == 4'hA) begin
					res0.action = bsm_pkg::ACT_PRG;
					res0.slot   = bsm_pkg::SLOT_PRG_A000;
					res0.bank   = data;
					n_res       = 2'd1;
				end else if (page == 4'h9 && low4 == 4'h0) begin
					res0.action     = bsm_pkg::ACT_MIRROR;
					res0.mirror_map = bsm_pkg::mirror_map_of(data[1:0]);
					n_res           = 2'd1;
				end else if (page == 4'h9 && (low4 == 4'h1 || low4 == 4'h4)) begin
					swap_d = data;
					if (swap_q[1] != data[1]) begin
						low_prg_d   = high_prg_q;
						high_prg_d  = low_prg_q;
						res0.action = bsm_pkg::ACT_PRG;
						res0.slot   = bsm_pkg::SLOT_PRG_8000;
						res0.bank   = high_prg_q;
						res1.action = bsm_pkg::ACT_PRG;
						res1.slot   = bsm_pkg::SLOT_PRG_C000;
						res1.bank   = low_prg_q;
						n_res       = 2'd2;
					end
				end else if (page >= 4'hB && page <= 4'hE) begin
					if (chr_ok) begin
						chr_we      = 1'b1;
						res0.action = bsm_pkg::ACT_CHR;
						res0.slot   = chr_idx;
						res0.bank   = chr_new;
						n_res       = 2'd1;
					end
				end else if (page == 4'hF) begin
					case (low4)
						4'h0: irq_reload_d = {irq_reload_q[7:4], data[3:0]};
						4'h2, 4'h8: irq_reload_d = {data[3:0], irq_reload_q[3:0]};
						4'h1, 4'h4: begin
							irq_en_d = data[1:0];
							if (data[1]) begin
								irq_count_d = irq_reload_q;
							end
						end
						4'h3, 4'hC: irq_en_d = {irq_en_q[0], irq_en_q[0]};
						default: ;
					endcase
				end
			end
			bsm_pkg::REQ_TICK: begin
				if (irq_en_q[1]) begin
					if (irq_count_q == fire_at) begin
						irq_count_d = irq_reload_q;
						res0.action = bsm_pkg::ACT_IRQ;
						n_res       = 2'd1;
					end else begin
						irq_count_d = irq_count_q + 8'd1;
					end
				end
			end
			bsm_pkg::REQ_INIT: begin
				chr_clear    = 1'b1;
				low_prg_d    = 8'h00;
				high_prg_d   = 8'(prg_bank_count - 9'd2);
				swap_d       = 8'h00;
				irq_en_d     = 2'b00;
				irq_count_d  = 8'h00;
				irq_reload_d = 8'h00;
			end
			default: ;
		endcase
		// mark the final result of the word
		if (n_res == 2'd1) begin
			res0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	// scalar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_prg_q    <= 8'h00;
			high_prg_q   <= bsm_pkg::HIGH_PRG_RST;
			swap_q       <= 8'h00;
			irq_en_q     <= 2'b00;
			irq_count_q  <= 8'h00;
			irq_reload_q <= 8'h00;
		end else if (go) begin
			low_prg_q    <= low_prg_d;
			high_prg_q   <= high_prg_d;
			swap_q       <= swap_d;
			irq_en_q     <= irq_en_d;
			irq_count_q  <= irq_count_d;
			irq_reload_q <= irq_reload_d;
		end
	end

	// picture bank file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
				chr_q[i] <= 8'h00;
			end
		end else if (go && chr_clear) begin
			for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
				chr_q[i] <= 8'h00;
			end
		end else if (go && chr_we) begin
			chr_q[chr_idx] <= chr_new;
		end
	end

	// a two-result word ends on its second result only
	assert property (@(posedge clk) disable iff (!arst_n)
		(n_res == 2'd2) |-> (res1.last && !res0.last))
		else $error("swap results marked wrong");

	// re-initialise leaves the low program bank, swap control and irq state cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && req_type == bsm_pkg::REQ_INIT) |=> (low_prg_q == 8'h00 && irq_en_q == 2'b00
			&& irq_count_q == 8'h00 && swap_q == 8'h00))
		else $error("re-initialise did not clear state");

	// an irq result only comes from an enabled tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(n_res != 2'd0 && res0.action == bsm_pkg::ACT_IRQ) |->
			(req_type == bsm_pkg::REQ_TICK && irq_en_q[1]))
		else $error("irq result without enabled tick");

endmodule

[hdl/bsm_res_fifo.sv]
// result queue taking up to two words a cycle while it has room for two, giving one when read
module bsm_res_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           n_push,
	input  bsm_pkg::result_t     din0,
	input  bsm_pkg::result_t     din1,
	output logic                 room2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bsm_pkg::result_t     dout
);

	bsm_pkg::result_t             mem_q [bsm_pkg::RQ_DEPTH];
	logic [bsm_pkg::RQ_PTR_W-1:0] wr_ptr_q;
	logic [bsm_pkg::RQ_PTR_W-1:0] rd_ptr_q;
	logic [bsm_pkg::RQ_CNT_W-1:0] count_q;
	logic [bsm_pkg::RQ_PTR_W-1:0] wr_ptr1;
	logic                         pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_ptr_q];
	assign room2     = (count_q <= bsm_pkg::RQ_CNT_W'(bsm_pkg::RQ_DEPTH - 2));
	assign wr_ptr1   = wr_ptr_q + 1'b1;

	// storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr1] <= din1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bsm_pkg::RQ_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + bsm_pkg::RQ_CNT_W'(n_push) - bsm_pkg::RQ_CNT_W'(pop);
		end
	end

	// never overfilled
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bsm_pkg::RQ_CNT_W'(bsm_pkg::RQ_DEPTH))
		else $error("result queue overflow");

	// pushes only with room for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |-> room2)
		else $error("push without room");

endmodule

[tb/bank_switch_mapper_irq_unit_tb.sv]
// self-checking testbench for the bank switch mapper with scanline irq
module bank_switch_mapper_irq_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// request kind the block ignores
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
	} bus_req_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [1:0]                     req_type = bsm_pkg::REQ_WRITE;
	logic [15:0]                    addr = '0;
	logic [7:0]                     data = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     action;
	logic [2:0]                     slot;
	logic [7:0]                     bank;
	logic [3:0]                     mirror_map;
	logic                           last;

	// mapper state as the testbench sees it
	logic [7:0] chr_bank [bsm_pkg::CHR_SLOTS];
	logic [7:0] prg_low, prg_high, swap_ctl, irq_cnt, irq_rld;
	logic [1:0] irq_en;
	logic       cfg_alt = 1'b0;
	logic [8:0] cfg_prg_count = bsm_pkg::PRG_COUNT_RST;

	bus_req_t          bus_reqs [$];
	bsm_pkg::result_t  due_results [$];
	bus_req_t          next_req, seen_req;
	bsm_pkg::result_t  want;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_sender = 1'b0;
	int  queued = 0;
	int  accepted = 0;
	int  checked = 0;
	int  errors = 0;
	int  irq_seen = 0;
	int  swap_seen = 0;

	bank_switch_mapper_irq_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.addr       (addr),
		.data       (data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.action     (action),
		.slot       (slot),
		.bank       (bank),
		.mirror_map (mirror_map),
		.last       (last)
	);

	// clock
	always #4 clk = ~clk;

	// nametable page map per mirroring mode
	function automatic logic [3:0] nametable_pages(input logic [1:0] mode);
		case (mode)
			2'd0:    return 4'b1010;
			2'd1:    return 4'b1100;
			2'd2:    return 4'b0000;
			default: return 4'b1111;
		endcase
	endfunction

	function automatic bsm_pkg::result_t word_of(input logic [1:0] act, input logic [2:0] sl,
			input logic [7:0] bk, input logic [3:0] mm);
		bsm_pkg::result_t w;
		w.action = act;
		w.slot = sl;
		w.bank = bk;
		w.mirror_map = mm;
		w.last = 1'b0;
		return w;
	endfunction

	// state after reset or a re-initialise request
	task automatic clear_mapper();
		foreach (chr_bank[i]) chr_bank[i] = 8'h00;
		prg_low = 8'h00;
		prg_high = 8'(cfg_prg_count - 9'd2);
		swap_ctl = 8'h00;
		irq_en = 2'b00;
		irq_cnt = 8'h00;
		irq_rld = 8'h00;
	endtask

	// update the mapper state for one accepted word and queue the result words it causes
	task automatic map_request(input bus_req_t r);
		bsm_pkg::result_t words [$];
		logic [3:0] page, low4;
		logic [15:0] sel;
		logic [7:0] tmp;
		int         idx;
		bit         hi_nib, hit;
		page = r.addr[15:12];
		low4 = r.addr[3:0];
		sel = r.addr & 16'hF00F;
		case (r.kind)
			bsm_pkg::REQ_WRITE: begin
				if (page == 4'h8) begin
					if (swap_ctl[1]) begin
						prg_high = r.data;
						words.push_back(word_of(bsm_pkg::ACT_PRG,
							bsm_pkg::SLOT_PRG_C000, r.data, 4'h0));
					end else begin
						prg_low = r.data;
						words.push_back(word_of(bsm_pkg::ACT_PRG,
							bsm_pkg::SLOT_PRG_8000, r.data, 4'h0));
					end
				end else if (page == 4'hA) begin
					words.push_back(word_of(bsm_pkg::ACT_PRG,
						bsm_pkg::SLOT_PRG_A000, r.data, 4'h0));
				end else if (sel == 16'h9000) begin
					words.push_back(word_of(bsm_pkg::ACT_MIRROR, 3'd0, 8'h00,
						nametable_pages(r.data[1:0])));
				end else if (sel == 16'h9001 || sel == 16'h9004) begin
					// swap bit flip exchanges the two program banks
					if (swap_ctl[1] != r.data[1]) begin
						tmp = prg_low;
						prg_low = prg_high;
						prg_high = tmp;
						words.push_back(word_of(bsm_pkg::ACT_PRG,
							bsm_pkg::SLOT_PRG_8000, prg_low, 4'h0));
						words.push_back(word_of(bsm_pkg::ACT_PRG,
							bsm_pkg::SLOT_PRG_C000, prg_high, 4'h0));
						swap_seen++;
					end
					swap_ctl = r.data;
				end else if (page >= 4'hB && page <= 4'hE) begin
					// picture bank nibble write
					hit = 1'b1;
					hi_nib = 1'b0;
					idx = (page - 4'hB) * 2;
					case (low4)
						4'h0: hi_nib = 1'b0;
						4'h1, 4'h4: idx++;
						4'h2, 4'h8: hi_nib = 1'b1;
						4'h3, 4'hC: begin
							idx++;
							hi_nib = 1'b1;
						end
						default: hit = 1'b0;
					endcase
					if (hit) begin
						if (hi_nib) chr_bank[idx][7:4] = r.data[3:0];
						else chr_bank[idx][3:0] = r.data[3:0];
						words.push_back(word_of(bsm_pkg::ACT_CHR, 3'(idx),
							chr_bank[idx], 4'h0));
					end
				end else if (page == 4'hF) begin
					// irq registers
					case (low4)
						4'h0: irq_rld[3:0] = r.data[3:0];
						4'h2, 4'h8: irq_rld[7:4] = r.data[3:0];
						4'h1, 4'h4: begin
							irq_en = r.data[1:0];
							if (irq_en[1]) irq_cnt = irq_rld;
						end
						4'h3, 4'hC: irq_en = {2{irq_en[0]}};
						default: ;
					endcase
				end
			end
			bsm_pkg::REQ_TICK: begin
				if (irq_en[1]) begin
					if (irq_cnt == (cfg_alt ? 8'h00 : 8'hFF)) begin
						irq_cnt = irq_rld;
						words.push_back(word_of(bsm_pkg::ACT_IRQ, 3'd0, 8'h00, 4'h0));
					end else begin
						irq_cnt = irq_cnt + 8'd1;
					end
				end
			end
			bsm_pkg::REQ_INIT: clear_mapper();
			default: ;
		endcase
		if (words.size() > 0) words[words.size()-1].last = 1'b1;
		foreach (words[i]) due_results.push_back(words[i]);
	endtask

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP) $display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic add_req(input logic [1:0] kind, input logic [15:0] a, input logic [7:0] d);
		bus_reqs.push_back({kind, a, d});
		if (kind != REQ_UNUSED) queued++;
	endtask

	// config writes happen only while the block is idle
	task automatic write_cfg(input logic [bsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bsm_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bsm_pkg::CFG_IRQ_ALT_MODE) cfg_alt = val[0];
		else cfg_prg_count = val;
	endtask

	// wait until every word is sent and every result word has come, plus pipeline slack
	task automatic wait_idle();
		while (bus_reqs.size() > 0 || in_valid || due_results.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// random words, mostly well-formed register sequences
	task automatic gen_random(input int n);
		int         start, pick, gap, ticks;
		logic [7:0] fire_at, rld;
		start = queued;
		fire_at = cfg_alt ? 8'h00 : 8'hFF;
		add_req(bsm_pkg::REQ_INIT, 16'($urandom), 8'($urandom));
		while (queued - start < n) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				case ($urandom_range(3))
					0: add_req(bsm_pkg::REQ_WRITE, {4'h8, 12'($urandom)}, 8'($urandom));
					1: add_req(bsm_pkg::REQ_WRITE, {4'hA, 12'($urandom)}, 8'($urandom));
					2: add_req(bsm_pkg::REQ_WRITE, {4'h9, 8'($urandom), 4'h0},
						8'($urandom));
					default: add_req(bsm_pkg::REQ_WRITE,
						{4'h9, 8'($urandom), ($urandom_range(1) ? 4'h1 : 4'h4)}, 8'($urandom));
				endcase
			end else if (pick < 60) begin
				case ($urandom_range(6))
					0: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h0}, 8'($urandom));
					1: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h1}, 8'($urandom));
					2: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h4}, 8'($urandom));
					3: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h2}, 8'($urandom));
					4: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h8}, 8'($urandom));
					5: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'h3}, 8'($urandom));
					default: add_req(bsm_pkg::REQ_WRITE,
						{4'(11 + $urandom_range(3)), 8'($urandom), 4'hC}, 8'($urandom));
				endcase
			end else if (pick < 75) begin
				// arm the irq close to its firing point, then tick past it
				gap = $urandom_range(12);
				rld = fire_at - 8'(gap);
				add_req(bsm_pkg::REQ_WRITE, {4'hF, 8'($urandom), 4'h0},
					{4'($urandom), rld[3:0]});
				add_req(bsm_pkg::REQ_WRITE,
					{4'hF, 8'($urandom), ($urandom_range(1) ? 4'h2 : 4'h8)},
					{4'($urandom), rld[7:4]});
				add_req(bsm_pkg::REQ_WRITE,
					{4'hF, 8'($urandom), ($urandom_range(1) ? 4'h1 : 4'h4)},
					{6'($urandom), 1'b1, 1'($urandom)});
				ticks = gap + 1 + $urandom_range(3);
				repeat (ticks) add_req(bsm_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
				if ($urandom_range(1))
					add_req(bsm_pkg::REQ_WRITE,
						{4'hF, 8'($urandom), ($urandom_range(1) ? 4'h3 : 4'hC)},
						8'($urandom));
			end else if (pick < 83) begin
				add_req(bsm_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
			end else if (pick < 88) begin
				add_req(bsm_pkg::REQ_WRITE, {4'hF, 12'($urandom)}, 8'($urandom));
			end else if (pick < 92) begin
				add_req(bsm_pkg::REQ_INIT, 16'($urandom), 8'($urandom));
			end else begin
				add_req(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic random_phase(input int s_idle, input int r_idle, input bit pause_midway);
		int target;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		target = accepted + ITEMS_PER_PHASE / 2;
		gen_random(ITEMS_PER_PHASE);
		if (pause_midway) begin
			// hold the sender until all outstanding result words are back
			while (accepted < target) @(negedge clk);
			hold_sender = 1'b1;
			while (in_valid || due_results.size() > 0) @(negedge clk);
			hold_sender = 1'b0;
		end
		wait_idle();
	endtask

	// word driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			seen_req = {req_type, addr, data};
			map_request(seen_req);
			accepted++;
		end
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (bus_reqs.size() > 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
				next_req = bus_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.kind;
				addr <= next_req.addr;
				data <= next_req.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected, action %0d", action));
			end else begin
				want = due_results.pop_front();
				if (action !== want.action)
					report_mismatch($sformatf("action %0d, expected %0d", action, want.action));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
				if (bank !== want.bank)
					report_mismatch($sformatf("bank %0h, expected %0h", bank, want.bank));
				if (mirror_map !== want.mirror_map)
					report_mismatch($sformatf("mirror_map %0h, expected %0h", mirror_map,
						want.mirror_map));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
				if (want.action == bsm_pkg::ACT_IRQ) irq_seen++;
				checked++;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	initial begin
		#3_200_000;
		$display("simulation failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		clear_mapper();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bank selects, mirroring, swaps, picture nibbles, unmapped, irq
		write_cfg(bsm_pkg::CFG_IRQ_ALT_MODE, 9'd0);
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd256);
		add_req(bsm_pkg::REQ_INIT, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h8000, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'hAFFF, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h9000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h9FF0, 8'h01);
		add_req(bsm_pkg::REQ_WRITE, 16'h9000, 8'h02);
		add_req(bsm_pkg::REQ_WRITE, 16'h9000, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'h9001, 8'h02);
		add_req(bsm_pkg::REQ_WRITE, 16'h9004, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'h8123, 8'h5A);
		add_req(bsm_pkg::REQ_WRITE, 16'h9004, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hB000, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'hB003, 8'hAB);
		add_req(bsm_pkg::REQ_WRITE, 16'hE00C, 8'hF0);
		add_req(bsm_pkg::REQ_WRITE, 16'hB005, 8'h11);
		add_req(bsm_pkg::REQ_WRITE, 16'h9002, 8'h33);
		add_req(bsm_pkg::REQ_WRITE, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hFFFF, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'hF000, 8'h0E);
		add_req(bsm_pkg::REQ_WRITE, 16'hF008, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'hF001, 8'h02);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_TICK, 16'hFFFF, 8'hFF);
		add_req(bsm_pkg::REQ_WRITE, 16'hF00C, 8'h00);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		add_req(REQ_UNUSED, 16'h8000, 8'h77);
		wait_idle();

		// alternate irq mode, wrapped program bank counts
		write_cfg(bsm_pkg::CFG_IRQ_ALT_MODE, 9'd1);
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd1);
		add_req(bsm_pkg::REQ_INIT, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h9001, 8'h02);
		add_req(bsm_pkg::REQ_WRITE, 16'hF000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hF002, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hF004, 8'h03);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hF001, 8'h01);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'hF003, 8'h00);
		add_req(bsm_pkg::REQ_TICK, 16'h0000, 8'h00);
		wait_idle();
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd511);
		add_req(bsm_pkg::REQ_INIT, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h9001, 8'h02);
		wait_idle();
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd0);
		add_req(bsm_pkg::REQ_INIT, 16'h0000, 8'h00);
		add_req(bsm_pkg::REQ_WRITE, 16'h9004, 8'h02);
		wait_idle();

		// random phases
		write_cfg(bsm_pkg::CFG_IRQ_ALT_MODE, 9'd0);
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd2);
		random_phase(7, 83, 1'b1);
		write_cfg(bsm_pkg::CFG_IRQ_ALT_MODE, 9'd1);
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'd256);
		random_phase(83, 7, 1'b0);
		write_cfg(bsm_pkg::CFG_IRQ_ALT_MODE, 9'($urandom_range(1)));
		write_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 9'($urandom_range(256, 2)));
		random_phase(0, 0, 1'b0);

		repeat (10) @(negedge clk);
		$display("run covered %0d requests over directed and random phases, %0d result words",
			accepted, checked);
		$display("irq requests %0d, program bank swaps %0d, mismatches %0d",
			irq_seen, swap_seen, errors);
		if (errors == 0 && due_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
hdl/bsm_pkg.sv
hdl/bsm_exec.sv
hdl/bsm_res_fifo.sv
hdl/bank_switch_mapper_irq_unit.sv
tb/bank_switch_mapper_irq_unit_tb.sv
